// ===== src/escape_time_fractal_pixel_core_defines.svh =====
// Assertion macros shared by the escape-time pixel core modules
`ifndef ESCAPE_TIME_FRACTAL_PIXEL_CORE_DEFINES_SVH
`define ESCAPE_TIME_FRACTAL_PIXEL_CORE_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while in reset
`define EFTP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset
`define EFTP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/eftp_pkg.sv =====
// Shared types and constants of the escape-time pixel core
package eftp_pkg;

    // One pixel request
    typedef struct packed {
        logic [11:0] pixel_column;
        logic [11:0] pixel_row;
        logic        last_pixel;
    } eftp_pixel_in_t;

    // One pixel result
    typedef struct packed {
        logic [15:0] iteration_count;
        logic        escaped;
        logic [63:0] final_magnitude;
        logic        last_pixel_out;
    } eftp_pixel_out_t;

    // Configuration register file contents
    typedef struct packed {
        logic [63:0] x_origin;
        logic [63:0] y_origin;
        logic [63:0] x_step;
        logic [63:0] y_step;
        logic [15:0] iteration_limit;
    } eftp_cfg_t;

    // Control from the sequencer to the shared multiplier
    typedef struct packed {
        logic start;  // latch operands and begin a product
        logic frac;   // 1: drop the fraction bits of the product, 0: keep the integer product
    } eftp_mul_ctl_t;

    // Configuration register indexes
    localparam logic [7:0] CFG_X_ORIGIN        = 8'd0;
    localparam logic [7:0] CFG_Y_ORIGIN        = 8'd1;
    localparam logic [7:0] CFG_X_STEP          = 8'd2;
    localparam logic [7:0] CFG_Y_STEP          = 8'd3;
    localparam logic [7:0] CFG_ITERATION_LIMIT = 8'd4;

    localparam logic [15:0] ITERATION_LIMIT_RESET = 16'd256;

    // Escape threshold on |z|^2, integer part
    localparam logic [6:0] ESCAPE_LIMIT = 7'd100;

    // Fraction bits of the reported magnitude
    localparam int MAG_FRAC_BITS = 48;

endpackage

// ===== src/eftp_mul.sv =====
// Shared sign-magnitude multiplier built from one 32x32 partial-product unit
`include "escape_time_fractal_pixel_core_defines.svh"

module eftp_mul
    import eftp_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 60,
    localparam int W = 16 + COORD_FRAC_BITS,
    localparam int OPW = (W > 64) ? W : 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  eftp_mul_ctl_t         ctl,
    input  logic signed [OPW-1:0] op_a,
    input  logic signed [OPW-1:0] op_b,
    output logic                  done,
    output logic signed [W-1:0]   res
);

    localparam int F  = COORD_FRAC_BITS;
    localparam int L  = (OPW + 31) / 32;
    localparam int PW = 64 * L;
    localparam int IW = (L > 1) ? $clog2(L) : 1;
    localparam int KW = $clog2(2 * L - 1);
    localparam logic [PW-1:0] TOP   = PW'(1) << (15 + F);
    localparam logic [PW-1:0] TOPM1 = TOP - PW'(1);

    logic [32*L-1:0] mag_a_reg;
    logic [32*L-1:0] mag_b_reg;
    logic            neg_reg;
    logic            frac_reg;
    logic            busy_reg;
    logic [IW-1:0]   i_reg;
    logic [IW-1:0]   j_reg;
    logic [63:0]     pp_reg;
    logic [KW-1:0]   k_reg;
    logic            pp_vld_reg;
    logic            last_reg;
    logic            fin_vld_reg;
    logic [PW-1:0]   acc_reg;
    logic [W-1:0]    res_reg;
    logic            done_reg;

    logic [OPW-1:0]  abs_a;
    logic [OPW-1:0]  abs_b;
    logic [31:0]     limb_a;
    logic [31:0]     limb_b;
    logic            last_issue;
    logic [PW-1:0]   r_sh;
    logic [PW-1:0]   cap;
    logic [PW-1:0]   m_cap;
    logic [W-1:0]    m_w;
    logic [W-1:0]    res_val;

    // Take magnitudes of the operands
    assign abs_a = op_a[OPW-1] ? OPW'(-op_a) : OPW'(op_a);
    assign abs_b = op_b[OPW-1] ? OPW'(-op_b) : OPW'(op_b);

    // Select the current limb pair
    assign limb_a     = mag_a_reg[32*i_reg +: 32];
    assign limb_b     = mag_b_reg[32*j_reg +: 32];
    assign last_issue = (i_reg == IW'(L - 1)) && (j_reg == IW'(L - 1));

    // Drop fraction bits when frac is set, clamp the magnitude, restore the sign
    always_comb begin
        r_sh    = frac_reg ? (acc_reg >> F) : acc_reg;
        cap     = neg_reg ? TOP : TOPM1;
        m_cap   = (r_sh > cap) ? cap : r_sh;
        m_w     = W'(m_cap);
        res_val = neg_reg ? (~m_w + W'(1)) : m_w;
    end

    // Issue partial products, accumulate, finish
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            pp_vld_reg  <= 1'b0;
            fin_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            done_reg    <= fin_vld_reg;
            fin_vld_reg <= pp_vld_reg && last_reg;
            pp_vld_reg  <= busy_reg;
            if (ctl.start) begin
                busy_reg  <= 1'b1;
                mag_a_reg <= (32*L)'(abs_a);
                mag_b_reg <= (32*L)'(abs_b);
                neg_reg   <= op_a[OPW-1] ^ op_b[OPW-1];
                frac_reg  <= ctl.frac;
                i_reg     <= '0;
                j_reg     <= '0;
                acc_reg   <= '0;
            end else if (busy_reg) begin
                pp_reg   <= 64'(limb_a) * 64'(limb_b);
                k_reg    <= KW'(i_reg) + KW'(j_reg);
                last_reg <= last_issue;
                if (last_issue) begin
                    busy_reg <= 1'b0;
                end
                if (j_reg == IW'(L - 1)) begin
                    j_reg <= '0;
                    i_reg <= i_reg + IW'(1);
                end else begin
                    j_reg <= j_reg + IW'(1);
                end
            end
            if (pp_vld_reg) begin
                acc_reg <= acc_reg + (PW'(pp_reg) << {k_reg, 5'd0});
            end
            if (fin_vld_reg) begin
                res_reg <= res_val;
            end
        end
    end

    assign done = done_reg;
    assign res  = $signed(res_reg);

    `EFTP_ASSERT_NOW(a_start_when_idle, ctl.start, !busy_reg && !pp_vld_reg && !fin_vld_reg, "multiplier started while a product is in flight")
    `EFTP_ASSERT_NEXT(a_done_single, done_reg, !done_reg, "multiplier done held longer than one cycle")

endmodule

// ===== src/eftp_seq.sv =====
// Per-pixel sequencer: coordinate mapping, z iteration, escape test
`include "escape_time_fractal_pixel_core_defines.svh"

module eftp_seq
    import eftp_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 60,
    localparam int W = 16 + COORD_FRAC_BITS,
    localparam int OPW = (W > 64) ? W : 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  eftp_pixel_in_t        in_item,
    output logic                  in_ready,
    input  eftp_cfg_t             cfg,
    output logic                  res_valid,
    input  logic                  res_ready,
    output eftp_pixel_out_t       res_item,
    output eftp_mul_ctl_t         mul_ctl,
    output logic signed [OPW-1:0] op_a,
    output logic signed [OPW-1:0] op_b,
    input  logic                  mul_done,
    input  logic signed [W-1:0]   mul_res
);

    localparam int F    = COORD_FRAC_BITS;
    localparam int RW   = W + 1;
    localparam int SW   = ((W > 64) ? W : 64) + 1;
    localparam int SATW = (SW > W + 2) ? SW : W + 2;
    localparam int SHR  = (F >= MAG_FRAC_BITS) ? F - MAG_FRAC_BITS : 0;
    localparam int SHL  = (F >= MAG_FRAC_BITS) ? 0 : MAG_FRAC_BITS - F;
    localparam logic signed [SATW-1:0] SAT_MAX = {{(SATW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SATW-1:0] SAT_MIN = {{(SATW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic [RW-1:0] LIMIT_MAG = RW'(ESCAPE_LIMIT) << F;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CX,
        S_CY,
        S_SQX,
        S_SQY,
        S_CHECK,
        S_TY,
        S_XX,
        S_YY,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    eftp_mul_ctl_t        ctl_reg, ctl_next;
    eftp_pixel_in_t       pix_reg, pix_next;
    logic signed [W-1:0]  cx_reg, cx_next;
    logic signed [W-1:0]  cy_reg, cy_next;
    logic signed [W-1:0]  x_reg, x_next;
    logic signed [W-1:0]  y_reg, y_next;
    logic signed [W-1:0]  t_reg, t_next;
    logic signed [W-1:0]  xs_reg, xs_next;
    logic signed [W-1:0]  ys_reg, ys_next;
    logic [RW-1:0]        radius_reg, radius_next;
    logic [15:0]          count_reg, count_next;

    logic                 esc_now;
    logic [RW+SHL-1:0]    mag_wide;
    logic signed [W-1:0]  coord_x;
    logic signed [W-1:0]  coord_y;
    logic signed [W-1:0]  y_iter;

    // Clamp a wide signed sum to the internal coordinate range
    function automatic logic signed [W-1:0] sat_w(input logic signed [SATW-1:0] v);
        if (v > SAT_MAX) begin
            return W'(SAT_MAX);
        end else if (v < SAT_MIN) begin
            return W'(SAT_MIN);
        end
        return W'(v);
    endfunction

    // Finish coordinates and the imaginary update from the multiplier result
    assign coord_x = sat_w(SATW'($signed(cfg.x_origin)) + SATW'(mul_res));
    assign coord_y = sat_w(SATW'($signed(cfg.y_origin)) + SATW'(mul_res));
    assign y_iter  = sat_w(SATW'(mul_res) + SATW'(cy_reg));

    assign esc_now = radius_reg > LIMIT_MAG;

    // Route multiplier operands for the current step
    always_comb begin
        case (state_reg)
            S_CX: begin
                op_a = OPW'($signed(cfg.x_step));
                op_b = OPW'(pix_reg.pixel_column);
            end
            S_CY: begin
                op_a = OPW'($signed(cfg.y_step));
                op_b = OPW'(pix_reg.pixel_row);
            end
            S_SQX: begin
                op_a = OPW'(cx_reg);
                op_b = OPW'(cx_reg);
            end
            S_SQY: begin
                op_a = OPW'(cy_reg);
                op_b = OPW'(cy_reg);
            end
            S_TY: begin
                op_a = OPW'(t_reg);
                op_b = OPW'(y_reg);
            end
            S_XX: begin
                op_a = OPW'(x_reg);
                op_b = OPW'(x_reg);
            end
            S_YY: begin
                op_a = OPW'(y_reg);
                op_b = OPW'(y_reg);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Advance the sequence
    always_comb begin
        state_next  = state_reg;
        ctl_next    = '0;
        pix_next    = pix_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        t_next      = t_reg;
        xs_next     = xs_reg;
        ys_next     = ys_reg;
        radius_next = radius_reg;
        count_next  = count_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    pix_next       = in_item;
                    state_next     = S_CX;
                    ctl_next.start = 1'b1;
                end
            end
            S_CX: begin
                if (mul_done) begin
                    cx_next        = coord_x;
                    state_next     = S_CY;
                    ctl_next.start = 1'b1;
                end
            end
            S_CY: begin
                if (mul_done) begin
                    cy_next        = coord_y;
                    x_next         = cx_reg;
                    y_next         = coord_y;
                    state_next     = S_SQX;
                    ctl_next.start = 1'b1;
                    ctl_next.frac  = 1'b1;
                end
            end
            S_SQX: begin
                if (mul_done) begin
                    xs_next        = mul_res;
                    state_next     = S_SQY;
                    ctl_next.start = 1'b1;
                    ctl_next.frac  = 1'b1;
                end
            end
            S_SQY: begin
                if (mul_done) begin
                    ys_next     = mul_res;
                    radius_next = '0;
                    count_next  = '0;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (esc_now || (count_reg >= cfg.iteration_limit)) begin
                    state_next = S_DONE;
                end else begin
                    t_next         = sat_w(SATW'(x_reg) + SATW'(x_reg));
                    x_next         = sat_w(SATW'(xs_reg) - SATW'(ys_reg) + SATW'(cx_reg));
                    state_next     = S_TY;
                    ctl_next.start = 1'b1;
                    ctl_next.frac  = 1'b1;
                end
            end
            S_TY: begin
                if (mul_done) begin
                    y_next         = y_iter;
                    state_next     = S_XX;
                    ctl_next.start = 1'b1;
                    ctl_next.frac  = 1'b1;
                end
            end
            S_XX: begin
                if (mul_done) begin
                    xs_next        = mul_res;
                    state_next     = S_YY;
                    ctl_next.start = 1'b1;
                    ctl_next.frac  = 1'b1;
                end
            end
            S_YY: begin
                if (mul_done) begin
                    ys_next     = mul_res;
                    radius_next = RW'($unsigned(xs_reg)) + RW'($unsigned(mul_res));
                    count_next  = count_reg + 16'd1;
                    state_next  = S_CHECK;
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, control and iteration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ctl_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            ctl_reg    <= ctl_next;
            pix_reg    <= pix_next;
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            t_reg      <= t_next;
            xs_reg     <= xs_next;
            ys_reg     <= ys_next;
            radius_reg <= radius_next;
            count_reg  <= count_next;
        end
    end

    // Move |z|^2 to the reported fraction width
    assign mag_wide = (RW+SHL)'(radius_reg) << SHL;

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign mul_ctl   = ctl_reg;

    always_comb begin
        res_item.iteration_count = count_reg;
        res_item.escaped         = esc_now;
        res_item.final_magnitude = 64'(mag_wide >> SHR);
        res_item.last_pixel_out  = pix_reg.last_pixel;
    end

    `EFTP_ASSERT_NOW(a_done_in_mul_step, (state_reg == S_IDLE) || (state_reg == S_CHECK) || (state_reg == S_DONE), !mul_done, "multiplier finished outside a multiply step")
    `EFTP_ASSERT_NEXT(a_count_step, (state_reg == S_YY) && mul_done, count_reg == $past(count_reg) + 16'd1, "iteration count did not advance by one")

endmodule

// ===== src/escape_time_fractal_pixel_core.sv =====
// Escape-time pixel core top level: configuration registers, channels, result register
//
// Usage: write x_origin, y_origin, x_step, y_step (signed, COORD_FRAC_BITS fraction
// bits) and iteration_limit on the cfg channel (index 0..4, other indexes ignored,
// always ready) while no pixel is in flight. Send pixels on s_*; each transaction
// yields one result transaction on m_* in the same order.
// Each multiply step on the shared 32x32 unit runs start, the L*L partial products,
// accumulate, finish and done in that order, where L = ceil(OPW/32) limbs and
// OPW = max(16 + COORD_FRAC_BITS, 64), so L = 3 at the default width. Each
// iteration of the loop runs three multiplies in turn through the single unit.
// Throughput: one pixel at a time; s_ready is high only while the core is idle.
// The finished result sits in an output register, so the next pixel is accepted
// while m_valid waits on m_ready; a second finished result waits in the core.
// Reset (aresetn low, synchronous): configuration registers return to zero,
// iteration_limit to 256, the core goes idle and m_valid drops.
`include "escape_time_fractal_pixel_core_defines.svh"

module escape_time_fractal_pixel_core
    import eftp_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 60
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [7:0]      cfg_index,
    input  logic [63:0]     cfg_data,
    input  logic            s_valid,
    output logic            s_ready,
    input  eftp_pixel_in_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output eftp_pixel_out_t m_data
);

    localparam int W   = 16 + COORD_FRAC_BITS;
    localparam int OPW = (W > 64) ? W : 64;

    eftp_cfg_t            cfg_reg;
    logic                 m_valid_reg;
    eftp_pixel_out_t      m_data_reg;

    logic                 in_ready;
    logic                 res_valid;
    logic                 out_free;
    eftp_pixel_out_t      res_item;
    eftp_mul_ctl_t        mul_ctl;
    logic signed [OPW-1:0] op_a;
    logic signed [OPW-1:0] op_b;
    logic                 mul_done;
    logic signed [W-1:0]  mul_res;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.x_origin        <= '0;
            cfg_reg.y_origin        <= '0;
            cfg_reg.x_step          <= '0;
            cfg_reg.y_step          <= '0;
            cfg_reg.iteration_limit <= ITERATION_LIMIT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_X_ORIGIN:        cfg_reg.x_origin        <= cfg_data;
                CFG_Y_ORIGIN:        cfg_reg.y_origin        <= cfg_data;
                CFG_X_STEP:          cfg_reg.x_step          <= cfg_data;
                CFG_Y_STEP:          cfg_reg.y_step          <= cfg_data;
                CFG_ITERATION_LIMIT: cfg_reg.iteration_limit <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    eftp_seq #(
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid && in_ready),
        .in_item   (s_data),
        .in_ready  (in_ready),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res_ready (out_free),
        .res_item  (res_item),
        .mul_ctl   (mul_ctl),
        .op_a      (op_a),
        .op_b      (op_b),
        .mul_done  (mul_done),
        .mul_res   (mul_res)
    );

    eftp_mul #(
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mul_ctl),
        .op_a    (op_a),
        .op_b    (op_b),
        .done    (mul_done),
        .res     (mul_res)
    );

    // Load the output register when it is empty or being drained
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && out_free) begin
            m_valid_reg <= 1'b1;
            m_data_reg  <= res_item;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign s_ready = in_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `EFTP_ASSERT_NEXT(a_one_pixel_in_flight, s_valid && s_ready, !s_ready, "second pixel accepted while one is in flight")

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the escape-time fractal pixel core
module tb;
    import eftp_pkg::*;

    localparam int          FRAC           = 60;
    localparam int unsigned WATCHDOG_LIMIT = 40000;
    localparam logic [63:0] COORD_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] COORD_MIN      = 64'h8000_0000_0000_0000;
    localparam logic [63:0] COORD_ONE      = 64'd1 << FRAC;

    typedef logic signed [127:0] q_wide_t;

    // Tracks register contents and the results still owed by the core
    class pixel_scoreboard;
        eftp_cfg_t       regs;
        eftp_pixel_out_t pending_pixels[$];
        int unsigned     mismatches;
        int unsigned     checked;

        function new();
            regs = '0;
            regs.iteration_limit = ITERATION_LIMIT_RESET;
            mismatches = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [7:0] index, logic [63:0] data);
            case (index)
                CFG_X_ORIGIN:        regs.x_origin = data;
                CFG_Y_ORIGIN:        regs.y_origin = data;
                CFG_X_STEP:          regs.x_step = data;
                CFG_Y_STEP:          regs.y_step = data;
                CFG_ITERATION_LIMIT: regs.iteration_limit = data[15:0];
                default: ;
            endcase
        endfunction

        // Clamp to the Q16.F range
        function q_wide_t clamp(q_wide_t a);
            q_wide_t top;
            top = q_wide_t'(1) <<< (15 + FRAC);
            if (a > top - 1) return top - 1;
            if (a < -top) return -top;
            return a;
        endfunction

        // Exact product, magnitude shifted right by sh, then clamped
        function q_wide_t scaled_product(q_wide_t a, q_wide_t b, int unsigned sh);
            logic [255:0] ma, mb, prod;
            logic [127:0] m, top;
            logic         neg;
            neg  = a[127] ^ b[127];
            ma   = {128'd0, (a[127] ? -a : a)};
            mb   = {128'd0, (b[127] ? -b : b)};
            prod = (ma * mb) >> sh;
            top  = 128'd1 << (15 + FRAC);
            m    = prod[127:0];
            if ((|prod[255:128]) || m > top) m = top;
            return clamp(neg ? -q_wide_t'(m) : q_wide_t'(m));
        endfunction

        function q_wide_t pixel_coord(logic [63:0] origin, logic [63:0] step,
                                      logic [11:0] index);
            return clamp(q_wide_t'(signed'(origin)) +
                         scaled_product(q_wide_t'(signed'(step)),
                                        q_wide_t'({116'd0, index}), 0));
        endfunction

        // Iterate z = z^2 + c for one pixel under the current registers
        function eftp_pixel_out_t escape_time(eftp_pixel_in_t px);
            q_wide_t         cx, cy, x, y, xs, ys, t, radius, bound;
            logic [127:0]    mag;
            int unsigned     count;
            eftp_pixel_out_t r;
            cx = pixel_coord(regs.x_origin, regs.x_step, px.pixel_column);
            cy = pixel_coord(regs.y_origin, regs.y_step, px.pixel_row);
            x = cx;
            y = cy;
            xs = scaled_product(x, x, FRAC);
            ys = scaled_product(y, y, FRAC);
            radius = '0;
            bound = q_wide_t'(ESCAPE_LIMIT) <<< FRAC;
            count = 0;
            while (!(radius > bound) && count < regs.iteration_limit) begin
                t = clamp(x + x);
                x = clamp(xs - ys + cx);
                y = clamp(scaled_product(t, y, FRAC) + cy);
                xs = scaled_product(x, x, FRAC);
                ys = scaled_product(y, y, FRAC);
                radius = xs + ys;
                count++;
            end
            if (FRAC >= MAG_FRAC_BITS) mag = radius >> (FRAC - MAG_FRAC_BITS);
            else mag = radius << (MAG_FRAC_BITS - FRAC);
            r.iteration_count = count[15:0];
            r.escaped         = radius > bound;
            r.final_magnitude = (|mag[127:64]) ? '1 : mag[63:0];
            r.last_pixel_out  = px.last_pixel;
            return r;
        endfunction

        function void note_request(eftp_pixel_in_t px);
            pending_pixels.push_back(escape_time(px));
        endfunction

        function void check_result(eftp_pixel_out_t got);
            eftp_pixel_out_t want;
            if (pending_pixels.size() == 0) begin
                $error("result with no pixel pending: iteration_count %0d",
                       got.iteration_count);
                mismatches++;
                return;
            end
            want = pending_pixels.pop_front();
            checked++;
            if (got.iteration_count !== want.iteration_count) begin
                $error("iteration_count: expected %0d, actual %0d",
                       want.iteration_count, got.iteration_count);
                mismatches++;
            end
            if (got.escaped !== want.escaped) begin
                $error("escaped: expected %0d, actual %0d", want.escaped, got.escaped);
                mismatches++;
            end
            if (got.final_magnitude !== want.final_magnitude) begin
                $error("final_magnitude: expected %h, actual %h",
                       want.final_magnitude, got.final_magnitude);
                mismatches++;
            end
            if (got.last_pixel_out !== want.last_pixel_out) begin
                $error("last_pixel_out: expected %0d, actual %0d",
                       want.last_pixel_out, got.last_pixel_out);
                mismatches++;
            end
        endfunction
    endclass

    logic            aclk;
    logic            aresetn;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [7:0]      cfg_index;
    logic [63:0]     cfg_data;
    logic            s_valid;
    logic            s_ready;
    eftp_pixel_in_t  s_data;
    logic            m_valid;
    logic            m_ready;
    eftp_pixel_out_t m_data;

    pixel_scoreboard sb = new();
    bit              idle_on;
    int unsigned     pixels_sent;
    int unsigned     settings_done;
    int unsigned     idle_cycles;

    escape_time_fractal_pixel_core #(
        .COORD_FRAC_BITS(FRAC)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic eftp_pixel_in_t pixel_at(logic [11:0] col, logic [11:0] row,
                                                logic last);
        eftp_pixel_in_t p;
        p.pixel_column = col;
        p.pixel_row    = row;
        p.last_pixel   = last;
        return p;
    endfunction

    // Random coordinate between lo and hi, given in units of 2^-20, with random low bits
    function automatic logic [63:0] region_value(int lo, int hi);
        longint     v;
        logic [39:0] low_bits;
        v = longint'(lo) + longint'($urandom_range(hi - lo, 0));
        low_bits = 40'({$urandom, $urandom});
        return 64'(v <<< 40) | {24'd0, low_bits};
    endfunction

    task automatic put_register(logic [7:0] index, logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(index, data);
    endtask

    // Write all registers, optionally preceded by a write to an unused index
    task automatic program_registers(logic [63:0] xo, logic [63:0] yo, logic [63:0] xs,
                                     logic [63:0] ys, logic [15:0] lim, bit with_junk);
        if (with_junk) put_register(8'($urandom_range(255, 5)), {$urandom, $urandom});
        put_register(CFG_X_ORIGIN, xo);
        put_register(CFG_Y_ORIGIN, yo);
        put_register(CFG_X_STEP, xs);
        put_register(CFG_Y_STEP, ys);
        put_register(CFG_ITERATION_LIMIT, {48'd0, lim});
        cfg_valid <= 1'b0;
        settings_done++;
    endtask

    // Offer one pixel, after an optional idle burst, and hold it until accepted
    task automatic send_pixel(eftp_pixel_in_t px);
        if (idle_on && $urandom_range(3, 0) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(19, 1)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(px);
        pixels_sent++;
    endtask

    // Drop valid and wait until every result of the phase is back
    task automatic end_phase();
        s_valid <= 1'b0;
        while (sb.pending_pixels.size() != 0) @(posedge aclk);
    endtask

    // Mostly short row scans ending on a last-of-row mark, some stray pixels
    task automatic scan_pixels(int unsigned n);
        logic [11:0] col, row;
        int unsigned run_left;
        run_left = 0;
        col = '0;
        row = '0;
        repeat (n) begin
            if ($urandom_range(7, 0) == 0) begin
                send_pixel(pixel_at(12'($urandom_range(4095, 0)), 12'($urandom_range(4095, 0)),
                                    1'($urandom_range(1, 0))));
            end else begin
                if (run_left == 0) begin
                    run_left = $urandom_range(8, 1);
                    col = 12'($urandom_range(4095, 0));
                    row = 12'($urandom_range(4095, 0));
                end
                run_left--;
                send_pixel(pixel_at(col, row, run_left == 0));
                col++;
            end
        end
    endtask

    // Result sink: check accepted results, stall in random bursts
    initial begin
        int unsigned stall;
        stall = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) sb.check_result(m_data);
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(7, 0) == 0) begin
                stall = $urandom_range(19, 1) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $error("no transaction for %0d cycles, %0d results pending",
               WATCHDOG_LIMIT, sb.pending_pixels.size());
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [15:0] lim;
        int unsigned n;
        int          span;
        bit          wild;
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        idle_on = 1'b1;
        pixels_sent = 0;
        settings_done = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset registers: c is zero, runs the full default limit
        send_pixel(pixel_at(12'd0, 12'd0, 1'b0));
        send_pixel(pixel_at(12'd4095, 12'd4095, 1'b1));
        end_phase();

        // Zero limit: no iteration at all
        program_registers({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                          {$urandom, $urandom}, 16'd0, 1'b1);
        send_pixel(pixel_at(12'd4095, 12'd0, 1'b1));
        send_pixel(pixel_at(12'd0, 12'd4095, 1'b0));
        send_pixel(pixel_at(12'd2730, 12'd1365, 1'b1));
        end_phase();

        // Extreme registers and the largest limit; every point lies far out
        program_registers(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 16'hFFFF, 1'b0);
        send_pixel(pixel_at(12'd0, 12'd0, 1'b1));
        send_pixel(pixel_at(12'd4095, 12'd4095, 1'b0));
        send_pixel(pixel_at(12'd0, 12'd4095, 1'b1));
        send_pixel(pixel_at(12'd4095, 12'd0, 1'b0));
        end_phase();

        // Opposite extremes with a limit of one
        program_registers(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 16'd1, 1'b1);
        send_pixel(pixel_at(12'd0, 12'd0, 1'b0));
        send_pixel(pixel_at(12'd4095, 12'd4095, 1'b1));
        send_pixel(pixel_at(12'd1, 12'd1, 1'b0));
        send_pixel(pixel_at(12'd2047, 12'd2048, 1'b1));
        end_phase();

        // Unit step on the real axis, limit one: only some of these points escape
        program_registers(64'd0, 64'd0, COORD_ONE, 64'd0, 16'd1, 1'b1);
        send_pixel(pixel_at(12'd0, 12'd7, 1'b0));
        send_pixel(pixel_at(12'd2, 12'd7, 1'b0));
        send_pixel(pixel_at(12'd3, 12'd7, 1'b0));
        send_pixel(pixel_at(12'd11, 12'd7, 1'b1));
        end_phase();

        // Random settings; the final phases run without idling
        for (int p = 0; p < 13; p++) begin
            if (p >= 11) idle_on = 1'b0;
            if (p % 4 == 3) begin
                lim = 16'($urandom_range(100, 33));
                n = 25;
            end else begin
                lim = ($urandom_range(11, 0) == 0) ? 16'd0 : 16'($urandom_range(24, 1));
                n = 69;
            end
            wild = ($urandom_range(5, 0) == 0);
            span = ($urandom_range(1, 0) == 0) ? 1024 : 16;
            if (wild)
                program_registers({$urandom, $urandom}, {$urandom, $urandom},
                                  {$urandom, $urandom}, {$urandom, $urandom}, lim,
                                  $urandom_range(3, 0) == 0);
            else
                program_registers(region_value(-2621440, 1048576),
                                  region_value(-1572864, 1572864),
                                  region_value(-span, span), region_value(-span, span), lim,
                                  $urandom_range(3, 0) == 0);
            scan_pixels(n);
            end_phase();
        end

        repeat (64) @(posedge aclk);
        if (sb.pending_pixels.size() != 0)
            $error("%0d pixels never returned a result", sb.pending_pixels.size());
        $display("Sent %0d pixels under %0d register settings, compared %0d results",
                 pixels_sent, settings_done, sb.checked);
        if (sb.mismatches == 0 && sb.pending_pixels.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/eftp_pkg.sv
src/eftp_mul.sv
src/eftp_seq.sv
src/escape_time_fractal_pixel_core.sv
tb/tb.sv
